// ===== design/lpc_pkg.sv =====
package lpc_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int TIME_BITS_DEF    = 32;
    localparam int MODE_BITS        = 3;
    localparam int IDX_BITS         = 2;
    localparam int DUR_BITS         = 16;
    localparam int OUT_BITS         = 4;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ON     = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_TOGGLE = 3'd2,
        MODE_BLINK  = 3'd3,
        MODE_TICK   = 3'd4
    } mode_t;

    // per channel control for one accepted item
    typedef struct packed {
        logic                tick;
        logic                hit;
        mode_t               mode;
        logic [DUR_BITS-1:0] dur;
    } chan_cmd_t;

endpackage

// ===== design/lpc_channel.sv =====
module lpc_channel #(
    parameter int TIME_BITS = lpc_pkg::TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpc_pkg::chan_cmd_t    cmd_i,
    input  logic [TIME_BITS-1:0]  now_i,
    input  logic [TIME_BITS-1:0]  now_inc_i,
    output logic                  lit_next_o
);

    logic                         lit_reg, lit_next;
    logic [TIME_BITS-1:0]         stamp_reg, stamp_next;
    logic [lpc_pkg::DUR_BITS-1:0] timeout_reg, timeout_next;
    logic [TIME_BITS-1:0]         elapsed;

    assign elapsed = now_inc_i - stamp_reg;

    always_comb begin
        lit_next     = lit_reg;
        stamp_next   = stamp_reg;
        timeout_next = timeout_reg;
        if (cmd_i.tick) begin
            if (lit_reg && timeout_reg != '0 &&
                elapsed >= TIME_BITS'(timeout_reg)) begin
                lit_next     = 1'b0;
                timeout_next = '0;
            end
        end else if (cmd_i.hit) begin
            case (cmd_i.mode)
                lpc_pkg::MODE_ON: begin
                    lit_next   = 1'b1;
                    stamp_next = now_i;
                end
                lpc_pkg::MODE_OFF: begin
                    lit_next = 1'b0;
                end
                lpc_pkg::MODE_TOGGLE: begin
                    if (lit_reg) begin
                        lit_next = 1'b0;
                    end else begin
                        lit_next   = 1'b1;
                        stamp_next = now_i;
                    end
                end
                lpc_pkg::MODE_BLINK: begin
                    lit_next     = 1'b1;
                    stamp_next   = now_i;
                    timeout_next = cmd_i.dur;
                end
                default: begin
                    lit_next = lit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg     <= 1'b0;
            stamp_reg   <= '0;
            timeout_reg <= '0;
        end else begin
            lit_reg     <= lit_next;
            stamp_reg   <= stamp_next;
            timeout_reg <= timeout_next;
        end
    end

    assign lit_next_o = lit_next;

endmodule

// ===== design/led_pulse_controller_unit.sv =====
// channel  | valid    | ready    | payload
// input    | s_valid  | s_ready  | s_mode, s_led_index, s_blink_duration
// result   | m_valid  | m_ready  | m_led_outputs
//
// one item per cycle while s_ready is high; its result shows the cycle after it is accepted
// channel state and the output register update at the accepting edge
// s_ready is low only while a result waits and m_ready is low
// synchronous active-low reset: all channels dark, timeouts and counter zero; the output register is not reset
module led_pulse_controller_unit #(
    parameter int NUM_CHANNELS = lpc_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = lpc_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lpc_pkg::MODE_BITS-1:0]  s_mode,
    input  logic [lpc_pkg::IDX_BITS-1:0]   s_led_index,
    input  logic [lpc_pkg::DUR_BITS-1:0]   s_blink_duration,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lpc_pkg::OUT_BITS-1:0]   m_led_outputs
);

    logic                          accept;
    lpc_pkg::mode_t                mode;
    logic                          is_tick;
    logic                          is_cmd;
    logic [TIME_BITS-1:0]          now_reg, now_next, now_inc;
    logic [NUM_CHANNELS-1:0]       lit_next;
    logic [lpc_pkg::OUT_BITS-1:0]  out_next;
    logic [lpc_pkg::OUT_BITS-1:0]  out_reg;
    logic                          m_valid_reg, m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign mode    = lpc_pkg::mode_t'(s_mode);
    assign is_tick = accept && mode == lpc_pkg::MODE_TICK;
    assign is_cmd  = accept && s_mode < lpc_pkg::MODE_TICK;
    assign now_inc = now_reg + TIME_BITS'(1);
    assign now_next = is_tick ? now_inc : now_reg;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        lpc_pkg::chan_cmd_t cmd;
        assign cmd.tick = is_tick;
        assign cmd.hit  = is_cmd && int'(s_led_index) == i;
        assign cmd.mode = mode;
        assign cmd.dur  = s_blink_duration;

        lpc_channel #(
            .TIME_BITS (TIME_BITS)
        ) u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd_i      (cmd),
            .now_i      (now_reg),
            .now_inc_i  (now_inc),
            .lit_next_o (lit_next[i])
        );
    end

    always_comb begin
        out_next = '0;
        for (int i = 0; i < lpc_pkg::OUT_BITS; i++) begin
            if (i < NUM_CHANNELS) begin
                out_next[i] = lit_next[i];
            end
        end
    end

    assign m_valid_next = accept ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_outputs = out_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick |=> now_reg == $past(now_reg) + TIME_BITS'(1))
        else $error("tick did not advance the counter");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && mode == lpc_pkg::MODE_OFF && s_led_index == '0
        |=> !m_led_outputs[0])
        else $error("off command left led lit");

endmodule

// ===== bench/led_pulse_controller_unit_test.sv =====
module led_pulse_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    class led_state_tracker;
        logic [31:0] now_ms;
        logic        lit [4];
        logic [31:0] stamp [4];
        logic [15:0] timeout [4];
        logic [3:0]  expected_leds [$];
        int          errors;

        function new();
            now_ms = '0;
            errors = 0;
            for (int i = 0; i < 4; i++) begin
                lit[i] = 1'b0;
                stamp[i] = '0;
                timeout[i] = '0;
            end
        endfunction

        function void light_channel(logic [1:0] idx);
            lit[idx] = 1'b1;
            stamp[idx] = now_ms;
        endfunction

        function void note_command(logic [2:0] mode, logic [1:0] idx, logic [15:0] dur);
            logic [3:0]  leds;
            logic [31:0] elapsed;
            case (mode)
                lpc_pkg::MODE_ON: begin
                    light_channel(idx);
                end
                lpc_pkg::MODE_OFF: begin
                    lit[idx] = 1'b0;
                end
                lpc_pkg::MODE_TOGGLE: begin
                    if (lit[idx]) begin
                        lit[idx] = 1'b0;
                    end else begin
                        light_channel(idx);
                    end
                end
                lpc_pkg::MODE_BLINK: begin
                    light_channel(idx);
                    timeout[idx] = dur;
                end
                lpc_pkg::MODE_TICK: begin
                    now_ms = now_ms + 32'd1;
                    for (int i = 0; i < 4; i++) begin
                        elapsed = now_ms - stamp[i];
                        if (lit[i] && timeout[i] != 16'd0 && elapsed >= {16'd0, timeout[i]}) begin
                            timeout[i] = '0;
                            lit[i] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
            for (int i = 0; i < 4; i++) begin
                leds[i] = lit[i];
            end
            expected_leds.push_back(leds);
        endfunction

        function void check_leds(logic [3:0] actual);
            logic [3:0] want;
            if (expected_leds.size() == 0) begin
                $error("led_outputs result with no item pending, actual %h", actual);
                errors++;
            end else begin
                want = expected_leds.pop_front();
                if (actual !== want) begin
                    $error("led_outputs expected %h actual %h", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [lpc_pkg::MODE_BITS-1:0]  s_mode;
    logic [lpc_pkg::IDX_BITS-1:0]   s_led_index;
    logic [lpc_pkg::DUR_BITS-1:0]   s_blink_duration;
    logic                           m_valid;
    logic                           m_ready;
    logic [lpc_pkg::OUT_BITS-1:0]   m_led_outputs;

    led_state_tracker sb = new();
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  cycle_count = 0;

    led_pulse_controller_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_led_index      (s_led_index),
        .s_blink_duration (s_blink_duration),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_led_outputs    (m_led_outputs)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_leds(m_led_outputs);
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic send_command(input logic [2:0] mode, input logic [1:0] idx,
                                input logic [15:0] dur);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_led_index <= idx;
        s_blink_duration <= dur;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_command(mode, idx, dur);
    endtask

    task automatic run_random(input int count);
        int          sent;
        int          pick;
        logic [2:0]  mode;
        logic [1:0]  idx;
        logic [15:0] dur;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99, 0);
            idx = 2'($urandom_range(3, 0));
            dur = 16'($urandom_range(65535, 0));
            if (pick < 38) begin
                mode = lpc_pkg::MODE_TICK;
            end else if (pick < 55) begin
                mode = lpc_pkg::MODE_BLINK;
                pick = $urandom_range(9, 0);
                if (pick < 6) begin
                    dur = 16'($urandom_range(12, 1));
                end else if (pick < 7) begin
                    dur = '0;
                end
            end else if (pick < 70) begin
                mode = lpc_pkg::MODE_ON;
            end else if (pick < 80) begin
                mode = lpc_pkg::MODE_OFF;
            end else if (pick < 95) begin
                mode = lpc_pkg::MODE_TOGGLE;
            end else begin
                mode = 3'($urandom_range(7, 5));
            end
            send_command(mode, idx, dur);
            if (mode <= lpc_pkg::MODE_TICK) begin
                sent++;
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mode <= lpc_pkg::MODE_ON;
        s_led_index <= '0;
        s_blink_duration <= '0;
        hold_req = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 64;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_command(lpc_pkg::MODE_ON, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_ON, 2'd1, 16'hffff);
        send_command(lpc_pkg::MODE_ON, 2'd2, 16'h0000);
        send_command(lpc_pkg::MODE_ON, 2'd3, 16'h0000);
        send_command(lpc_pkg::MODE_ON, 2'd3, 16'h0000);
        send_command(lpc_pkg::MODE_OFF, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_OFF, 2'd3, 16'h0000);
        send_command(lpc_pkg::MODE_TOGGLE, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_TOGGLE, 2'd1, 16'h0000);
        send_command(lpc_pkg::MODE_BLINK, 2'd2, 16'hffff);
        send_command(lpc_pkg::MODE_BLINK, 2'd3, 16'h0000);
        send_command(lpc_pkg::MODE_TICK, 2'd3, 16'hffff);
        send_command(lpc_pkg::MODE_BLINK, 2'd1, 16'h0001);
        send_command(lpc_pkg::MODE_TICK, 2'd0, 16'h0000);
        // leftover duration: off keeps the timeout, a later on times out again
        send_command(lpc_pkg::MODE_BLINK, 2'd0, 16'h0002);
        send_command(lpc_pkg::MODE_OFF, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_ON, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_TICK, 2'd0, 16'h0000);
        send_command(lpc_pkg::MODE_TICK, 2'd0, 16'h0000);
        // unknown modes leave everything as is
        send_command(3'd5, 2'd3, 16'hffff);
        send_command(3'd6, 2'd2, 16'h5555);
        send_command(3'd7, 2'd1, 16'haaaa);
        send_command(lpc_pkg::MODE_TOGGLE, 2'd2, 16'h0000);
        send_command(lpc_pkg::MODE_TOGGLE, 2'd2, 16'h0000);

        run_random(400);
        send_idle_pct = 64;
        recv_idle_pct = 24;
        run_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(200);
        hold_req = 1'b1;
        run_random(200);
        s_valid <= 1'b0;

        while (sb.expected_leds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_leds.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
